>>> sv/ecu_pkg.sv
// Shared constants, codes and arithmetic helpers of the easing curve unit.
`default_nettype none

package ecu_pkg;

  // Internal fixed-point format: signed Q24 (2^24 = 1.0).
  localparam int    IQ  = 24;
  localparam longint ONE = 64'sd1 <<< IQ;

  // Fraction bits of progress and of the eased result (Q1.14 in, Q2.14 out).
  localparam int FRAC_BITS = 14;

  // Back-curve constants in Q24.
  localparam longint C1_Q24    = 64'sd28547775;
  localparam longint C3_Q24    = C1_Q24 + ONE;
  localparam longint K1525_Q24 = 64'sd25585254;
  localparam longint C2_Q24    = (C1_Q24 * K1525_Q24 + (64'sd1 <<< (IQ - 1))) >>> IQ;
  localparam longint C2P1_Q24  = C2_Q24 + ONE;

  // Gains of the second and third arch of the elastic up-down curve.
  localparam longint GAIN_MID_Q24 = -64'sd6710886;
  localparam longint GAIN_END_Q24 = 64'sd2516582;

  // Reciprocal of three, exact for dividends below 2^29.
  localparam longint unsigned DIV3_MUL   = 64'd357913942;
  localparam int              DIV3_SHIFT = 30;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned LN2_Q30     = 64'd744261118;

  typedef enum logic [3:0] {
    ACT_NONE            = 4'd0,
    ACT_IN              = 4'd1,
    ACT_OUT             = 4'd2,
    ACT_IN_BACK         = 4'd3,
    ACT_OUT_BACK        = 4'd4,
    ACT_IN_OUT_BACK     = 4'd5,
    ACT_IN_ELASTIC      = 4'd6,
    ACT_OUT_ELASTIC     = 4'd7,
    ACT_UP_DOWN         = 4'd8,
    ACT_UP_DOWN_ELASTIC = 4'd9
  } action_t;

  // Shift right by s with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] mag;
    logic [63:0] rounded;
    mag     = v[63] ? 64'(-v) : 64'(v);
    rounded = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(rounded) : $signed(rounded);
  endfunction

  // Product of two Q24 values, rounded back to Q24.
  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return rnd_shift(p, IQ);
  endfunction

  // Unsigned long division by shift and subtract, used only while the
  // tables are built at elaboration.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int bi = 63; bi >= 0; bi--) begin
      rem = {rem[62:0], num[bi]};
      if (rem >= den) begin
        rem    = rem - den;
        q[bi]  = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine table entry in Q24, evaluated at elaboration.
  function automatic longint unsigned sin_rom_entry(input int i, input int tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (PI_HALF_Q30 * longint'(i) + (64'd1 << (tb - 1))) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 12; k++) begin
      term = udiv((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return (longint'(sum) + 64'd32) >> 6;
  endfunction

  // Table entry of 2^(i / 2^tb) in Q24, evaluated at elaboration.
  function automatic longint unsigned exp2_rom_entry(input int i, input int tb);
    longint unsigned y;
    longint unsigned term;
    longint unsigned sum;
    y    = (LN2_Q30 * longint'(i) + (64'd1 << (tb - 1))) >> tb;
    term = 64'd1 << 30;
    sum  = term;
    for (int k = 1; k <= 14; k++) begin
      term = udiv((term * y) >> 30, 64'(k));
      sum  = sum + term;
    end
    return (sum + 64'd32) >> 6;
  endfunction

endpackage

`default_nettype wire

>>> sv/ecu_sine.sv
// Two-stage sine of a phase in 24-bit turns from an interpolated quarter-wave table.
`default_nettype none

module ecu_sine #(
  parameter int TABLE_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               en_a,
  input  wire logic               en_b,
  input  wire logic [23:0]        phase,
  output logic signed [25:0]      sine
);

  localparam int SH    = 22 - TABLE_BITS;
  localparam int DEPTH = (2 ** TABLE_BITS) + 1;
  localparam int IW    = TABLE_BITS + 1;

  logic [24:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [24:0] ENTRY = 25'(ecu_pkg::sin_rom_entry(i, TABLE_BITS));
    assign rom[i] = ENTRY;
  end

  logic [22:0]   r;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_b;

  always_comb begin
    r     = phase[22] ? (23'(1) << 22) - {1'b0, phase[21:0]} : {1'b0, phase[21:0]};
    idx   = r[22:SH];
    idx_b = (idx == IW'(2 ** TABLE_BITS)) ? idx : idx + IW'(1);
  end

  logic [24:0]   a;
  logic [24:0]   b;
  logic [SH-1:0] fr;
  logic          neg;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a   <= rom[idx];
      b   <= rom[idx_b];
      fr  <= r[SH-1:0];
      neg <= phase[23];
    end
  end

  logic [24:0]      b_clip;
  logic [24+SH:0]   step;
  logic [24:0]      mag;

  always_comb begin
    b_clip = (b < a) ? a : b;
    step   = (24+SH+1)'(b_clip - a) * (24+SH+1)'(fr) + ((24+SH+1)'(1) << (SH - 1));
    mag    = a + 25'(step >> SH);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      sine <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

>>> sv/ecu_pow2.sv
// Three-stage 2^e for a Q24 exponent in [-16, 1) from an interpolated table.
`default_nettype none

module ecu_pow2 #(
  parameter int TABLE_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               en_a,
  input  wire logic               en_b,
  input  wire logic               en_c,
  input  wire logic signed [28:0] expo,
  output logic signed [26:0]      pow
);

  localparam int SH    = ecu_pkg::IQ - TABLE_BITS;
  localparam int DEPTH = (2 ** TABLE_BITS) + 1;
  localparam int IW    = TABLE_BITS + 1;

  logic [25:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [25:0] ENTRY = 26'(ecu_pkg::exp2_rom_entry(i, TABLE_BITS));
    assign rom[i] = ENTRY;
  end

  logic [IW-1:0]     idx;
  logic signed [4:0] ip;

  always_comb begin
    idx = {1'b0, expo[23:SH]};
    ip  = expo[28:24];
  end

  logic [25:0]   a;
  logic [25:0]   b;
  logic [SH-1:0] fr;
  logic [4:0]    sa;
  logic [4:0]    sb;
  logic [25:0]   v;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a  <= rom[idx];
      b  <= rom[idx + IW'(1)];
      fr <= expo[SH-1:0];
      sa <= ip[4] ? 5'(-ip) : 5'd0;
    end
  end

  logic [25+SH:0] step;

  always_comb begin
    step = (26+SH)'(b - a) * (26+SH)'(fr) + ((26+SH)'(1) << (SH - 1));
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      v  <= a + 26'(step >> SH);
      sb <= sa;
    end
  end

  // Negative integer part: shift down with rounding; a zero shift adds nothing.
  logic [26:0] half;
  logic [26:0] shifted;

  always_comb begin
    half    = (27'(1) << sb) >> 1;
    shifted = ({1'b0, v} + half) >> sb;
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      pow <= $signed(shifted);
    end
  end

endmodule

`default_nettype wire

>>> sv/easing_curve_unit.sv
// Top level of the easing curve unit: seven-stage pipeline over ten curves.
`default_nettype none

// Channel   Beat fields                 Handshake
// ------    -------------------------   -------------------------------------
// input     action[3:0], progress[14:0] in_valid (driven in), in_stall (out)
// output    eased[15:0] signed Q2.14     out_valid (driven out), out_stall (in)
//
// Each beat passes every stage register to the output, and one beat can
// be accepted in every cycle unless stalled; the depth is set by the chain
// of multiplies in the back curves and the table lookup, interpolation and
// scaling of the elastic curves. Reset clears only the stage valid bits.
// A stage moves forward when it is empty or when the stage after it moves,
// so a stall at the output fills the bubbles before it reaches the input.

module easing_curve_unit #(
  parameter int TABLE_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         action,
  input  wire logic [14:0]        progress,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      eased
);

  localparam int          XSH    = ecu_pkg::IQ - ecu_pkg::FRAC_BITS;
  localparam int unsigned ONE_IN = 32'd1 << ecu_pkg::FRAC_BITS;

  // Q24 constants of the curve setup: one half, and the phase offsets of the
  // elastic in and out curves (5/4 and 45/4 of a turn before the division).
  localparam logic signed [29:0] HALF_Q24   = 30'(ecu_pkg::ONE / 2);
  localparam logic signed [29:0] PH_IN_Q24  = 30'((ecu_pkg::ONE * 5) / 4);
  localparam logic signed [29:0] PH_OUT_Q24 = 30'((ecu_pkg::ONE * 45) / 4);

  typedef enum logic [1:0] {
    SEG_ARCH,
    SEG_MID,
    SEG_END
  } seg_t;

  // ---------------------------------------------------------------------
  // Stage control. Valid bits travel with the data; each stage loads when
  // it is empty or when its contents move on.
  // ---------------------------------------------------------------------
  logic [7:1] vld;
  logic [7:1] en;

  always_comb begin
    en[7] = !vld[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: progress above one saturates, then moves to Q24.
  // ---------------------------------------------------------------------
  logic [31:0] prog_ext;
  logic [31:0] n_clip;

  always_comb begin
    prog_ext = 32'(progress);
    n_clip   = (prog_ext > ONE_IN) ? ONE_IN : prog_ext;
  end

  logic [3:0]  act1;
  logic [24:0] x1;
  logic        n0_1;
  logic        n1_1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      act1 <= action;
      x1   <= 25'(n_clip << XSH);
      n0_1 <= (progress == '0);
      n1_1 <= (prog_ext >= ONE_IN);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: curve setup. The cubic base, the sine phase (or the dividend
  // for a phase that needs a division by three), the exponent of the
  // elastic decay and the segment of the elastic up-down curve.
  // ---------------------------------------------------------------------
  logic signed [29:0] xs;
  logic signed [29:0] ten_x;
  logic signed [29:0] five_x;
  logic signed [29:0] num_c;
  logic signed [29:0] m_c;
  logic signed [29:0] e_c;
  logic [23:0]        dph_c;
  logic               div_c;
  seg_t               seg_c;
  logic               half_c;

  always_comb begin
    xs     = $signed({5'b0, x1});
    ten_x  = (xs <<< 3) + (xs <<< 1);
    five_x = (xs <<< 2) + xs;
    half_c = (xs >= HALF_Q24);

    if (!half_c) begin
      seg_c = SEG_ARCH;
    end else if (five_x < 30'(4 * ecu_pkg::ONE)) begin
      seg_c = SEG_MID;
    end else begin
      seg_c = SEG_END;
    end

    m_c   = xs;
    num_c = '0;
    e_c   = '0;
    dph_c = x1[23:0];
    div_c = 1'b0;

    unique case (act1) inside
      ecu_pkg::ACT_OUT: begin
        m_c = 30'(ecu_pkg::ONE) - xs;
      end
      ecu_pkg::ACT_OUT_BACK: begin
        m_c = xs - 30'(ecu_pkg::ONE);
      end
      ecu_pkg::ACT_IN_OUT_BACK: begin
        m_c = half_c ? (xs <<< 1) - 30'(2 * ecu_pkg::ONE) : (xs <<< 1);
      end
      ecu_pkg::ACT_IN_ELASTIC: begin
        num_c = ten_x + PH_IN_Q24 + 30'sd1;
        e_c   = ten_x - 30'(10 * ecu_pkg::ONE);
        div_c = 1'b1;
      end
      ecu_pkg::ACT_OUT_ELASTIC: begin
        num_c = ten_x + PH_OUT_Q24 + 30'sd1;
        e_c   = -ten_x;
        div_c = 1'b1;
      end
      ecu_pkg::ACT_UP_DOWN: begin
        dph_c = 24'(xs >>> 1);
      end
      ecu_pkg::ACT_UP_DOWN_ELASTIC: begin
        // The middle arch needs (10n - 5 + 3) / 6, taken as a halving and
        // then a division by three.
        num_c = (ten_x - 30'(5 * ecu_pkg::ONE) + 30'sd3) >>> 1;
        div_c = (seg_c == SEG_MID);
        if (seg_c == SEG_END) begin
          dph_c = 24'((five_x - 30'(4 * ecu_pkg::ONE) + 30'sd1) >>> 1);
        end
      end
      default: begin
        m_c = xs;
      end
    endcase
  end

  logic [3:0]         act2;
  logic [24:0]        x2;
  logic               n0_2;
  logic               n1_2;
  logic               half2;
  seg_t               seg2;
  logic signed [25:0] m2;
  logic [28:0]        num2;
  logic [23:0]        dph2;
  logic               div2;
  logic signed [28:0] e2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      act2  <= act1;
      x2    <= x1;
      n0_2  <= n0_1;
      n1_2  <= n1_1;
      half2 <= half_c;
      seg2  <= seg_c;
      m2    <= 26'(m_c);
      num2  <= 29'(num_c);
      dph2  <= dph_c;
      div2  <= div_c;
      e2    <= 29'(e_c);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: square of the base, the linear term of the back in-out curve,
  // and the division by three of the phase through a reciprocal.
  // ---------------------------------------------------------------------
  logic signed [63:0] sq_c;
  logic signed [63:0] cq_c;
  logic signed [63:0] u_c;
  logic [57:0]        quot_c;

  always_comb begin
    sq_c   = ecu_pkg::qmul(32'(m2), 32'(m2));
    cq_c   = ecu_pkg::qmul(32'(ecu_pkg::C2P1_Q24), 32'(m2));
    u_c    = half2 ? cq_c + ecu_pkg::C2_Q24 : cq_c - ecu_pkg::C2_Q24;
    quot_c = 58'(num2) * 58'(ecu_pkg::DIV3_MUL);
  end

  logic [3:0]         act3;
  logic [24:0]        x3;
  logic               n0_3;
  logic               n1_3;
  logic               half3;
  seg_t               seg3;
  logic signed [25:0] m3;
  logic signed [25:0] p2_3;
  logic signed [27:0] u3;
  logic [23:0]        ph3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      act3  <= act2;
      x3    <= x2;
      n0_3  <= n0_2;
      n1_3  <= n1_2;
      half3 <= half2;
      seg3  <= seg2;
      m3    <= m2;
      p2_3  <= 26'(sq_c);
      u3    <= 28'(u_c);
      ph3   <= div2 ? quot_c[ecu_pkg::DIV3_SHIFT +: 24] : dph2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: cube of the base, or for the back in-out curve the square of
  // t times its linear term. The sine and pow2 units run alongside.
  // ---------------------------------------------------------------------
  logic signed [63:0] prod_c;

  always_comb begin
    prod_c = ecu_pkg::qmul(32'(p2_3),
                           (act3 == ecu_pkg::ACT_IN_OUT_BACK) ? 32'(u3) : 32'(m3));
  end

  logic [3:0]         act4;
  logic [24:0]        x4;
  logic               n0_4;
  logic               n1_4;
  logic               half4;
  seg_t               seg4;
  logic signed [25:0] p2_4;
  logic signed [27:0] prod4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      act4  <= act3;
      x4    <= x3;
      n0_4  <= n0_3;
      n1_4  <= n1_3;
      half4 <= half3;
      seg4  <= seg3;
      p2_4  <= p2_3;
      prod4 <= 28'(prod_c);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: the two weighted terms of the back in and back out curves.
  // ---------------------------------------------------------------------
  logic [3:0]         act5;
  logic [24:0]        x5;
  logic               n0_5;
  logic               n1_5;
  logic               half5;
  seg_t               seg5;
  logic signed [27:0] prod5;
  logic signed [27:0] ra5;
  logic signed [27:0] rb5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      act5  <= act4;
      x5    <= x4;
      n0_5  <= n0_4;
      n1_5  <= n1_4;
      half5 <= half4;
      seg5  <= seg4;
      prod5 <= prod4;
      ra5   <= 28'(ecu_pkg::qmul(32'(ecu_pkg::C3_Q24), 32'(prod4)));
      rb5   <= 28'(ecu_pkg::qmul(32'(ecu_pkg::C1_Q24), 32'(p2_4)));
    end
  end

  // Sine of the stage 3 phase, ready at stage 5.
  logic signed [25:0] sine5;

  ecu_sine #(
    .TABLE_BITS (TABLE_BITS)
  ) u_sine (
    .clk   (clk),
    .en_a  (en[4]),
    .en_b  (en[5]),
    .phase (ph3),
    .sine  (sine5)
  );

  // Elastic decay 2^e from the stage 2 exponent, ready at stage 5.
  logic signed [26:0] pw5;

  ecu_pow2 #(
    .TABLE_BITS (TABLE_BITS)
  ) u_pow2 (
    .clk  (clk),
    .en_a (en[3]),
    .en_b (en[4]),
    .en_c (en[5]),
    .expo (e2),
    .pow  (pw5)
  );

  // ---------------------------------------------------------------------
  // Stage 6: the final Q24 value of each curve. The elastic curves scale
  // the sine by the decay, the elastic up-down curve by its arch gain.
  // ---------------------------------------------------------------------
  logic               elastic;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] q_c;
  logic signed [63:0] v_c;

  always_comb begin
    elastic = (act5 == ecu_pkg::ACT_IN_ELASTIC) || (act5 == ecu_pkg::ACT_OUT_ELASTIC);
    opa     = elastic ? 32'(pw5) : 32'(sine5);
    if (elastic) begin
      opb = 32'(sine5);
    end else if (seg5 == SEG_MID) begin
      opb = 32'(ecu_pkg::GAIN_MID_Q24);
    end else begin
      opb = 32'(ecu_pkg::GAIN_END_Q24);
    end
    q_c = ecu_pkg::qmul(opa, opb);

    unique case (act5) inside
      ecu_pkg::ACT_IN: begin
        v_c = 64'(prod5);
      end
      ecu_pkg::ACT_OUT: begin
        v_c = ecu_pkg::ONE - 64'(prod5);
      end
      ecu_pkg::ACT_IN_BACK: begin
        v_c = 64'(ra5) - 64'(rb5);
      end
      ecu_pkg::ACT_OUT_BACK: begin
        v_c = ecu_pkg::ONE + 64'(ra5) + 64'(rb5);
      end
      ecu_pkg::ACT_IN_OUT_BACK: begin
        v_c = half5 ? ecu_pkg::rnd_shift(64'(prod5) + 2 * ecu_pkg::ONE, 1)
                    : ecu_pkg::rnd_shift(64'(prod5), 1);
      end
      ecu_pkg::ACT_IN_ELASTIC, ecu_pkg::ACT_OUT_ELASTIC: begin
        // The elastic curves land exactly on their end points.
        if (n0_5) begin
          v_c = '0;
        end else if (n1_5) begin
          v_c = ecu_pkg::ONE;
        end else if (act5 == ecu_pkg::ACT_IN_ELASTIC) begin
          v_c = -q_c;
        end else begin
          v_c = q_c + ecu_pkg::ONE;
        end
      end
      ecu_pkg::ACT_UP_DOWN: begin
        v_c = 64'(sine5);
      end
      ecu_pkg::ACT_UP_DOWN_ELASTIC: begin
        v_c = (seg5 == SEG_ARCH) ? 64'(sine5) : q_c;
      end
      default: begin
        // Linear, and selector codes without a curve, pass n through.
        v_c = 64'($signed({1'b0, x5}));
      end
    endcase
  end

  logic signed [29:0] v6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      v6 <= 30'(v_c);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: round to nearest into the output format and saturate to 16 bits.
  // ---------------------------------------------------------------------
  logic signed [63:0] rs;
  logic signed [15:0] sat;

  always_comb begin
    rs = ecu_pkg::rnd_shift(64'(v6), XSH);
    if (rs > 64'sd32767) begin
      sat = 16'sh7FFF;
    end else if (rs < -64'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = 16'(rs);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      eased <= sat;
    end
  end

endmodule

`default_nettype wire
